// File: design/serial_frame_receiver_defines.svh
// assertion macros used by the checker file sfr_chk.sv
`ifndef SERIAL_FRAME_RECEIVER_DEFINES_SVH
`define SERIAL_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SFR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfr assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfr assertion failed");

`endif

// File: design/sfr_pkg.sv
`default_nettype none

package sfr_pkg;

  // payload storage
  localparam int unsigned MaxPayloadWords = 63;
  localparam int unsigned RamDepth        = 64;
  localparam int unsigned RamAw           = $clog2(RamDepth);
  localparam logic [6:0]  MaxPayloadBytes = 7'(2 * MaxPayloadWords);
  localparam logic [6:0]  LenClamp        = 7'd127;

  // register map, one word per register
  typedef enum logic [2:0] {
    RegStartMarker = 3'd0,
    RegEndMarker   = 3'd1,
    RegSpecialId   = 3'd2,
    RegUnblockThr  = 3'd3,
    RegMaxPayload  = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StLenErr = 2'd1,
    StEndErr = 2'd2,
    StChkErr = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    PhHunt  = 3'd0,
    PhSeq   = 3'd1,
    PhLen   = 3'd2,
    PhChk   = 3'd3,
    PhId    = 3'd4,
    PhData  = 3'd5,
    PhEnd   = 3'd6,
    PhDrain = 3'd7
  } phase_e;

  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
    logic [7:0] special_id;
    logic [7:0] unblock_thr;
    logic [6:0] max_payload;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic    cap_seq;
    logic    cap_len;
    logic    cap_chk;
    logic    cap_id;
    logic    cap_data;
    logic    end_chk;
    logic    res_load;
    status_e res_status;
    logic    res_unblk;
    logic    drain_start;
    logic    drain_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start_hit;
    logic len_bad;
    logic len_zero;
    logic data_done;
    logic end_ok;
    logic special;
    logic xor_ok;
    logic drain_last;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

// File: design/sfr_ram.sv
`default_nettype none

module sfr_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: design/sfr_regs.sv
`default_nettype none

module sfr_regs import sfr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  // register write decode
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegStartMarker: cfg_d.start_marker = pwdata[7:0];
        RegEndMarker:   cfg_d.end_marker   = pwdata[7:0];
        RegSpecialId:   cfg_d.special_id   = pwdata[7:0];
        RegUnblockThr:  cfg_d.unblock_thr  = pwdata[7:0];
        RegMaxPayload:  cfg_d.max_payload  = pwdata[6:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= 8'd0;
      cfg_q.end_marker   <= 8'd255;
      cfg_q.special_id   <= 8'd0;
      cfg_q.unblock_thr  <= 8'd4;
      cfg_q.max_payload  <= 7'd126;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      RegStartMarker: prdata = {24'd0, cfg_q.start_marker};
      RegEndMarker:   prdata = {24'd0, cfg_q.end_marker};
      RegSpecialId:   prdata = {24'd0, cfg_q.special_id};
      RegUnblockThr:  prdata = {24'd0, cfg_q.unblock_thr};
      RegMaxPayload:  prdata = {25'd0, cfg_q.max_payload};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// File: design/sfr_ctrl.sv
`default_nettype none

module sfr_ctrl import sfr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic rx_valid_i,
  input  wire logic res_ready_i,
  input  sts_t      sts_i,
  output logic      rx_ready_o,
  output cmd_t      cmd_o
);

  phase_e state_q, state_d;
  logic   out_free;
  logic   take;

  assign out_free   = !sts_i.out_busy || res_ready_i;
  assign rx_ready_o = (state_q != PhDrain) && out_free;
  assign take       = rx_valid_i && rx_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PhHunt;
    end else begin
      state_q <= state_d;
    end
  end

  // frame sequencing
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      PhHunt: begin
        if (take && sts_i.start_hit) begin
          state_d = PhSeq;
        end
      end
      PhSeq: begin
        if (take) begin
          cmd_o.cap_seq = 1'b1;
          state_d       = PhLen;
        end
      end
      PhLen: begin
        if (take) begin
          cmd_o.cap_len = 1'b1;
          state_d       = PhChk;
        end
      end
      PhChk: begin
        if (take) begin
          cmd_o.cap_chk = 1'b1;
          state_d       = PhId;
        end
      end
      PhId: begin
        if (take) begin
          cmd_o.cap_id = 1'b1;
          if (sts_i.len_bad) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = StLenErr;
            state_d          = PhHunt;
          end else if (sts_i.len_zero) begin
            state_d = PhEnd;
          end else begin
            state_d = PhData;
          end
        end
      end
      PhData: begin
        if (take) begin
          cmd_o.cap_data = 1'b1;
          if (sts_i.data_done) begin
            state_d = PhEnd;
          end
        end
      end
      PhEnd: begin
        if (take) begin
          cmd_o.end_chk = 1'b1;
          state_d       = PhHunt;
          if (!sts_i.end_ok) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = StEndErr;
          end else if (!sts_i.xor_ok) begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = StChkErr;
          end else if (sts_i.special) begin
            cmd_o.res_load  = 1'b1;
            cmd_o.res_unblk = 1'b1;
          end else if (sts_i.len_zero) begin
            cmd_o.res_load = 1'b1;
          end else begin
            cmd_o.drain_start = 1'b1;
            state_d           = PhDrain;
          end
        end
      end
      PhDrain: begin
        if (out_free) begin
          cmd_o.drain_step = 1'b1;
          if (sts_i.drain_last) begin
            state_d = PhHunt;
          end
        end
      end
      default: state_d = PhHunt;
    endcase
  end

endmodule

`default_nettype wire

// File: design/sfr_dp.sv
`default_nettype none

module sfr_dp import sfr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  rx_byte_i,
  input  cfg_t             cfg_i,
  input  cmd_t             cmd_i,
  input  wire logic        res_ready_i,
  output sts_t             sts_o,
  output logic             res_valid_o,
  output logic             has_word_o,
  output logic      [15:0] data_word_o,
  output logic      [7:0]  device_id_o,
  output logic      [7:0]  sequence_res_o,
  output logic      [1:0]  status_o,
  output logic             unblock_received_o,
  output logic             send_unblock_o,
  output logic             last_o
);

  logic [7:0]       seq_q, chk_q, id_q, xor_q, high_q, cnt_q;
  logic [6:0]       len_q, bs_q;
  logic             send_q;
  logic [RamAw-1:0] ridx_q;
  logic             res_valid_q, has_q, unblk_q, rsend_q, last_q;
  logic [15:0]      word_q;
  status_e          status_q;

  logic [6:0]       bs_inc;
  logic [RamAw-1:0] words;
  logic [8:0]       cnt_inc;
  logic             send_hit;
  logic             ram_we, ram_re;
  logic [RamAw-1:0] ram_waddr, ram_raddr;
  logic [15:0]      ram_rdata;

  assign bs_inc  = bs_q + 7'd1;
  assign words   = len_q[RamAw:1];
  assign cnt_inc = {1'b0, cnt_q} + 9'd1;

  // frame checks
  assign sts_o.start_hit  = (rx_byte_i == cfg_i.start_marker);
  assign sts_o.len_bad    = len_q[0] || (len_q > cfg_i.max_payload) ||
                            (len_q > MaxPayloadBytes);
  assign sts_o.len_zero   = (len_q == 7'd0);
  assign sts_o.data_done  = (bs_inc >= len_q);
  assign sts_o.end_ok     = (rx_byte_i == cfg_i.end_marker);
  assign sts_o.special    = (id_q == cfg_i.special_id);
  assign sts_o.xor_ok     = (xor_q == chk_q);
  assign sts_o.drain_last = (ridx_q == words - RamAw'(1));
  assign sts_o.out_busy   = res_valid_q;

  // receive count reaching the threshold on a good end byte
  assign send_hit = sts_o.end_ok && !sts_o.special && (cnt_inc >= {1'b0, cfg_i.unblock_thr});

  // payload store: words written on odd bytes, read back in order
  assign ram_we    = cmd_i.cap_data && bs_q[0];
  assign ram_waddr = bs_q[RamAw:1];
  assign ram_re    = cmd_i.drain_start || cmd_i.drain_step;
  assign ram_raddr = cmd_i.drain_start ? '0 : ridx_q + RamAw'(1);

  sfr_ram #(
    .Width (16),
    .Depth (RamDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({high_q, rx_byte_i}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // header, checksum and byte tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= 8'd0;
      len_q  <= 7'd0;
      chk_q  <= 8'd0;
      id_q   <= 8'd0;
      xor_q  <= 8'd0;
      bs_q   <= 7'd0;
      high_q <= 8'd0;
      cnt_q  <= 8'd0;
      send_q <= 1'b0;
      ridx_q <= '0;
    end else begin
      if (cmd_i.cap_seq) begin
        seq_q <= rx_byte_i;
        xor_q <= rx_byte_i;
      end
      if (cmd_i.cap_len) begin
        len_q <= rx_byte_i[7] ? LenClamp : rx_byte_i[6:0];
        xor_q <= xor_q ^ rx_byte_i;
      end
      if (cmd_i.cap_chk) begin
        chk_q <= rx_byte_i;
      end
      if (cmd_i.cap_id) begin
        id_q  <= rx_byte_i;
        xor_q <= xor_q ^ rx_byte_i;
        bs_q  <= 7'd0;
      end
      if (cmd_i.cap_data) begin
        xor_q <= xor_q ^ rx_byte_i;
        bs_q  <= bs_inc;
        if (!bs_q[0]) begin
          high_q <= rx_byte_i;
        end
      end
      if (cmd_i.end_chk) begin
        send_q <= send_hit;
        if (sts_o.end_ok && !sts_o.special) begin
          cnt_q <= send_hit ? 8'd0 : cnt_inc[7:0];
        end
      end
      if (cmd_i.drain_start) begin
        ridx_q <= '0;
      end else if (cmd_i.drain_step) begin
        ridx_q <= ridx_q + RamAw'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (cmd_i.res_load || cmd_i.drain_step) begin
      res_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      has_q    <= 1'b0;
      word_q   <= 16'd0;
      status_q <= cmd_i.res_status;
      unblk_q  <= cmd_i.res_unblk;
      rsend_q  <= cmd_i.end_chk && send_hit;
      last_q   <= 1'b1;
    end else if (cmd_i.drain_step) begin
      has_q    <= 1'b1;
      word_q   <= ram_rdata;
      status_q <= StOk;
      unblk_q  <= 1'b0;
      rsend_q  <= send_q;
      last_q   <= sts_o.drain_last;
    end
  end

  assign res_valid_o        = res_valid_q;
  assign has_word_o         = has_q;
  assign data_word_o        = word_q;
  assign device_id_o        = id_q;
  assign sequence_res_o     = seq_q;
  assign status_o           = status_q;
  assign unblock_received_o = unblk_q;
  assign send_unblock_o     = rsend_q;
  assign last_o             = last_q;

endmodule

`default_nettype wire

// File: design/serial_frame_receiver.sv
// serial frame receiver
// rx channel (rx_valid_i / rx_ready_o / rx_byte_i) takes one byte per transaction.
// bytes are dropped until the start marker; then sequence, length, checksum, id,
// length payload bytes and the end byte follow. the res channel (res_valid_o /
// res_ready_i) gives one transaction per payload word of a good frame, with last_o
// on the final word, or a single transaction for an error, special or empty frame.
// throughput: one rx byte per cycle while a frame is received and rx_ready_o high.
// a single result is registered and shows in the cycle after the byte that caused
// it; after the end byte the words go through the payload ram's registered read
// port and the result register, one word per cycle while res_ready_i is high.
// rx_ready_o is low while words are drained (up to 63 words) and while a result
// waits with res_ready_i low; a stalled result holds its fields.
// registers sit on an apb port at byte offsets 0,4,8,12,16: start marker, end
// marker, special id, unblock threshold, max payload bytes.
// reset: registers take their defaults, the receiver hunts for a start marker,
// the frame count clears and no result is pending.
`default_nettype none

module serial_frame_receiver import sfr_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        rx_valid_i,
  output logic             rx_ready_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output logic             has_word_o,
  output logic      [15:0] data_word_o,
  output logic      [7:0]  device_id_o,
  output logic      [7:0]  sequence_res_o,
  output logic      [1:0]  status_o,
  output logic             unblock_received_o,
  output logic             send_unblock_o,
  output logic             last_o
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  sfr_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sfr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .res_ready_i (res_ready_i),
    .sts_i       (sts),
    .rx_ready_o  (rx_ready_o),
    .cmd_o       (cmd)
  );

  sfr_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .rx_byte_i          (rx_byte_i),
    .cfg_i              (cfg),
    .cmd_i              (cmd),
    .res_ready_i        (res_ready_i),
    .sts_o              (sts),
    .res_valid_o        (res_valid_o),
    .has_word_o         (has_word_o),
    .data_word_o        (data_word_o),
    .device_id_o        (device_id_o),
    .sequence_res_o     (sequence_res_o),
    .status_o           (status_o),
    .unblock_received_o (unblock_received_o),
    .send_unblock_o     (send_unblock_o),
    .last_o             (last_o)
  );

endmodule

`default_nettype wire

// File: design/sfr_chk.sv
`default_nettype none

`include "serial_frame_receiver_defines.svh"

module sfr_chk import sfr_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        psel,
  input wire logic        penable,
  input wire logic        pwrite,
  input wire logic [4:0]  paddr,
  input wire logic [31:0] pwdata,
  input wire logic [31:0] prdata,
  input wire logic        pready,
  input wire logic        rx_valid_i,
  input wire logic        rx_ready_o,
  input wire logic [7:0]  rx_byte_i,
  input wire logic        res_valid_o,
  input wire logic        res_ready_i,
  input wire logic        has_word_o,
  input wire logic [15:0] data_word_o,
  input wire logic [7:0]  device_id_o,
  input wire logic [7:0]  sequence_res_o,
  input wire logic [1:0]  status_o,
  input wire logic        unblock_received_o,
  input wire logic        send_unblock_o,
  input wire logic        last_o
);

  // a stalled result keeps its word
  `SFR_ASSERT_NEXT(a_res_hold, res_valid_o && !res_ready_i, res_valid_o && $stable(data_word_o))

  // no byte is taken while a result is stalled
  `SFR_ASSERT_IMPL(a_rx_blocked, res_valid_o && !res_ready_i, !rx_ready_o)

  // a word only travels in an ok frame
  `SFR_ASSERT_IMPL(a_word_ok, res_valid_o && has_word_o, status_o == StOk && !unblock_received_o)

  // error and unblock results are single, wordless and last
  `SFR_ASSERT_IMPL(a_single_res, res_valid_o && (status_o != StOk || unblock_received_o),
                   last_o && !has_word_o)

endmodule

bind serial_frame_receiver sfr_chk u_sfr_chk (.*);

`default_nettype wire

// File: bench/serial_frame_receiver_test.sv
`timescale 1ns / 1ps

module serial_frame_receiver_test;
  import sfr_pkg::*;

  typedef struct packed {
    logic        has_word;
    logic [15:0] data_word;
    logic [7:0]  device_id;
    logic [7:0]  sequence_res;
    status_e     status;
    logic        unblock_received;
    logic        send_unblock;
    logic        last;
  } frame_result_t;

  // clock, reset and block ports
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        rx_valid_i = 1'b0;
  logic        rx_ready_o;
  logic [7:0]  rx_byte_i = '0;
  logic        res_valid_o;
  logic        res_ready_i = 1'b0;
  logic        has_word_o;
  logic [15:0] data_word_o;
  logic [7:0]  device_id_o;
  logic [7:0]  sequence_res_o;
  logic [1:0]  status_o;
  logic        unblock_received_o;
  logic        send_unblock_o;
  logic        last_o;

  // register shadows, reset values
  logic [7:0] cfg_start = 8'd0;
  logic [7:0] cfg_end = 8'd255;
  logic [7:0] cfg_special = 8'd0;
  logic [7:0] cfg_thr = 8'd4;
  logic [6:0] cfg_max = 7'd126;

  // frame decoder state
  phase_e      frame_phase = PhHunt;
  logic [7:0]  hdr_seq = '0;
  logic [6:0]  hdr_len = '0;
  logic [7:0]  hdr_chk = '0;
  logic [7:0]  hdr_id = '0;
  logic [7:0]  frame_xor = '0;
  logic [6:0]  data_cnt = '0;
  logic [7:0]  hi_byte = '0;
  logic [7:0]  good_frames = '0;
  logic [15:0] word_mem [64];

  logic [7:0]    rx_bytes_q [$];
  frame_result_t frame_results_q [$];
  frame_result_t expected_res;
  int unsigned   mismatches = 0;

  // driver bookkeeping
  logic        next_valid;
  logic [7:0]  next_byte;
  int unsigned burst_left;
  int unsigned gap_left;

  // receiver stall pattern
  logic [15:0] ready_mask;
  logic [3:0]  mask_pos;

  serial_frame_receiver u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .rx_valid_i         (rx_valid_i),
    .rx_ready_o         (rx_ready_o),
    .rx_byte_i          (rx_byte_i),
    .res_valid_o        (res_valid_o),
    .res_ready_i        (res_ready_i),
    .has_word_o         (has_word_o),
    .data_word_o        (data_word_o),
    .device_id_o        (device_id_o),
    .sequence_res_o     (sequence_res_o),
    .status_o           (status_o),
    .unblock_received_o (unblock_received_o),
    .send_unblock_o     (send_unblock_o),
    .last_o             (last_o)
  );

  // 10 ns clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // queue one expected result of the current frame
  function automatic void post_result(logic has, logic [15:0] word, status_e st,
                                      logic unblk, logic send, logic fin);
    frame_result_t r;
    r.has_word         = has;
    r.data_word        = word;
    r.device_id        = hdr_id;
    r.sequence_res     = hdr_seq;
    r.status           = st;
    r.unblock_received = unblk;
    r.send_unblock     = send;
    r.last             = fin;
    frame_results_q.push_back(r);
  endfunction

  // advance the frame decoder by one received byte
  function automatic void decode_rx_byte(logic [7:0] b);
    logic       special;
    logic       send;
    logic [8:0] cnt;
    logic [5:0] nwords;
    case (frame_phase)
      PhHunt: begin
        if (b == cfg_start) frame_phase = PhSeq;
      end
      PhSeq: begin
        hdr_seq     = b;
        frame_xor   = b;
        frame_phase = PhLen;
      end
      PhLen: begin
        // lengths above 127 clamp to an odd value and fail later
        hdr_len     = b[7] ? 7'd127 : b[6:0];
        frame_xor   = frame_xor ^ b;
        frame_phase = PhChk;
      end
      PhChk: begin
        hdr_chk     = b;
        frame_phase = PhId;
      end
      PhId: begin
        hdr_id    = b;
        frame_xor = frame_xor ^ b;
        data_cnt  = '0;
        if (hdr_len[0] || hdr_len > cfg_max || hdr_len > MaxPayloadBytes) begin
          frame_phase = PhHunt;
          post_result(1'b0, 16'h0, StLenErr, 1'b0, 1'b0, 1'b1);
        end else begin
          frame_phase = (hdr_len == 0) ? PhEnd : PhData;
        end
      end
      PhData: begin
        frame_xor = frame_xor ^ b;
        if (!data_cnt[0]) hi_byte = b;
        else word_mem[data_cnt[6:1]] = {hi_byte, b};
        data_cnt = data_cnt + 7'd1;
        if (data_cnt >= hdr_len) frame_phase = PhEnd;
      end
      PhEnd: begin
        frame_phase = PhHunt;
        special     = (hdr_id == cfg_special);
        send        = 1'b0;
        nwords      = hdr_len[6:1];
        if (b != cfg_end) begin
          post_result(1'b0, 16'h0, StEndErr, 1'b0, 1'b0, 1'b1);
        end else begin
          // counted whether or not the checksum matches
          if (!special) begin
            cnt = {1'b0, good_frames} + 9'd1;
            if (cnt >= {1'b0, cfg_thr}) begin
              send = 1'b1;
              cnt  = '0;
            end
            good_frames = cnt[7:0];
          end
          if (frame_xor != hdr_chk) begin
            post_result(1'b0, 16'h0, StChkErr, 1'b0, send, 1'b1);
          end else if (special) begin
            post_result(1'b0, 16'h0, StOk, 1'b1, send, 1'b1);
          end else if (nwords == 0) begin
            post_result(1'b0, 16'h0, StOk, 1'b0, send, 1'b1);
          end else begin
            for (int i = 0; i < nwords; i++)
              post_result(1'b1, word_mem[i], StOk, 1'b0, send, (i + 1 == nwords));
          end
        end
      end
      default: frame_phase = PhHunt;
    endcase
  endfunction

  // rx driver: bursts of random length with random gaps
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_valid_i <= 1'b0;
      rx_byte_i  <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      next_valid = rx_valid_i;
      next_byte  = rx_byte_i;
      // accepted transaction feeds the decoder
      if (rx_valid_i && rx_ready_o) begin
        decode_rx_byte(rx_byte_i);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (rx_bytes_q.size() != 0) begin
          next_valid = 1'b1;
          next_byte  = rx_bytes_q.pop_front();
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      rx_valid_i <= next_valid;
      rx_byte_i  <= next_byte;
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // result monitor and receiver stall pattern
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_ready_i <= 1'b0;
      ready_mask  = 16'hffff;
      mask_pos    = '0;
    end else begin
      if (res_valid_o && res_ready_i) begin
        if (frame_results_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none actual word %0h status %0d",
                   $time, data_word_o, status_o);
          mismatches++;
        end else begin
          expected_res = frame_results_q.pop_front();
          check_field("has_word", expected_res.has_word, has_word_o);
          check_field("data_word", expected_res.data_word, data_word_o);
          check_field("device_id", expected_res.device_id, device_id_o);
          check_field("sequence_res", expected_res.sequence_res, sequence_res_o);
          check_field("status", expected_res.status, status_o);
          check_field("unblock_received", expected_res.unblock_received,
                      unblock_received_o);
          check_field("send_unblock", expected_res.send_unblock, send_unblock_o);
          check_field("last", expected_res.last, last_o);
        end
      end
      // new stall pattern each time the mask position wraps, sometimes none at all
      if (mask_pos == 0) begin
        case ($urandom_range(0, 3))
          0: ready_mask = 16'hffff;
          1: ready_mask = 16'($urandom) | 16'h0001;
          2: ready_mask = 16'($urandom) | 16'($urandom) | 16'h0001;
          default: ready_mask = 16'($urandom) & 16'($urandom) | 16'h0001;
        endcase
      end
      res_ready_i <= ready_mask[mask_pos];
      mask_pos = mask_pos + 4'd1;
    end
  end

  // apb write: setup then access cycle
  task automatic set_reg(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegStartMarker: cfg_start   = val[7:0];
      RegEndMarker:   cfg_end     = val[7:0];
      RegSpecialId:   cfg_special = val[7:0];
      RegUnblockThr:  cfg_thr     = val[7:0];
      RegMaxPayload:  cfg_max     = val[6:0];
      default: ;
    endcase
  endtask

  task automatic set_all(logic [7:0] st, logic [7:0] en, logic [7:0] sp,
                         logic [7:0] thr, logic [6:0] mx);
    set_reg(RegStartMarker, {24'h0, st});
    set_reg(RegEndMarker, {24'h0, en});
    set_reg(RegSpecialId, {24'h0, sp});
    set_reg(RegUnblockThr, {24'h0, thr});
    set_reg(RegMaxPayload, {25'h0, mx});
  endtask

  // queue one frame; a frame with a bad length stops after its id byte
  task automatic push_frame(logic [7:0] seq, logic [7:0] lenb, logic [7:0] id,
                            logic [7:0] flip, logic [7:0] endb);
    logic [7:0] body [$];
    logic [7:0] x;
    logic [6:0] n;
    logic       ok;
    n  = lenb[7] ? 7'd127 : lenb[6:0];
    ok = !n[0] && n <= cfg_max && n <= MaxPayloadBytes;
    x  = seq ^ lenb ^ id;
    if (ok) begin
      for (int i = 0; i < n; i++) begin
        body.push_back(8'($urandom));
        x = x ^ body[i];
      end
    end
    rx_bytes_q.push_back(cfg_start);
    rx_bytes_q.push_back(seq);
    rx_bytes_q.push_back(lenb);
    rx_bytes_q.push_back(x ^ flip);
    rx_bytes_q.push_back(id);
    if (ok) begin
      foreach (body[i]) rx_bytes_q.push_back(body[i]);
      rx_bytes_q.push_back(endb);
    end
  endtask

  // mostly well-formed frames with random content, some broken, noise between
  task automatic random_frames(int unsigned n);
    int unsigned target;
    int unsigned pick;
    int unsigned lim;
    logic [7:0]  lenb;
    logic [7:0]  id;
    logic [7:0]  flip;
    logic [7:0]  endb;
    logic [7:0]  noise;
    target = rx_bytes_q.size() + n;
    while (rx_bytes_q.size() < target) begin
      lim  = (cfg_max > MaxPayloadBytes) ? MaxPayloadBytes : cfg_max;
      lim  = lim & ~1;
      pick = $urandom_range(0, 99);
      if (pick < 6) lenb = 8'($urandom_range(0, 127)) | 8'h01;
      else if (pick < 10) lenb = 8'($urandom_range(lim + 1, 255));
      else lenb = 8'(2 * $urandom_range(0, ((lim < 16) ? lim : 16) / 2));
      id   = ($urandom_range(0, 4) == 0) ? cfg_special : 8'($urandom);
      flip = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
      endb = ($urandom_range(0, 9) == 0) ? cfg_end ^ 8'($urandom_range(1, 255)) : cfg_end;
      push_frame(8'($urandom), lenb, id, flip, endb);
      repeat ($urandom_range(0, 2)) begin
        noise = 8'($urandom);
        while (noise == cfg_start) noise = 8'($urandom);
        rx_bytes_q.push_back(noise);
      end
    end
  endtask

  // all bytes sent, all results seen, then a pause for the drain to settle
  task automatic wait_quiet();
    @(negedge clk_i);
    while (rx_bytes_q.size() != 0 || rx_valid_i || frame_results_q.size() != 0)
      @(negedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames on reset settings
    rx_bytes_q.push_back(8'h5a);
    rx_bytes_q.push_back(8'hff);
    push_frame(8'hff, 8'd0, 8'h01, 8'h00, 8'hff);   // empty frame
    push_frame(8'h00, 8'd2, 8'h80, 8'h00, 8'hff);   // start marker value as sequence
    push_frame(8'h01, 8'd3, 8'h02, 8'h00, 8'hff);   // odd length
    push_frame(8'h02, 8'hff, 8'h03, 8'h00, 8'hff);  // length above 127
    push_frame(8'h03, 8'd2, 8'h04, 8'h01, 8'hff);   // bad checksum
    push_frame(8'h04, 8'd0, 8'h05, 8'h00, 8'hfe);   // bad end byte
    push_frame(8'h05, 8'd2, 8'h00, 8'h00, 8'hff);   // special frame
    push_frame(8'h06, 8'd0, 8'h07, 8'h00, 8'hff);   // reaches threshold
    wait_quiet();

    // random markers, unblock on every frame with a good end byte that is not special
    set_all(8'($urandom), 8'($urandom), 8'($urandom), 8'd1, 7'd126);
    random_frames(8);
    wait_quiet();

    // extreme settings, no payload allowed
    set_all(8'd255, 8'd0, 8'd255, 8'd255, 7'd0);
    random_frames(8);
    wait_quiet();

    // random settings
    set_all(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom_range(2, 6)),
            7'($urandom_range(0, 126)));
    random_frames(8);
    wait_quiet();

    // one full-size frame, then random ones
    set_all(8'($urandom), 8'($urandom), 8'($urandom), 8'd3, 7'd126);
    push_frame(8'($urandom), 8'd126, cfg_special ^ 8'h01, 8'h00, cfg_end);
    random_frames(8);
    wait_quiet();

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
